// ===== rtl/core/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants for the drive command parser with watchdog.
// ----------------------------------------------------------------------------
package pdc_pkg;

   // Command text and control characters.
   localparam logic [2:0] PREFIX_LEN = 3'd6;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_I     = 8'h49;
   localparam logic [7:0] CHAR_V     = 8'h56;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_TIMEOUT_TICKS  = 3'd0;
   localparam logic [2:0] CSR_PWM_PERIOD     = 3'd1;
   localparam logic [2:0] CSR_PWM_ON_COUNT   = 3'd2;
   localparam logic [2:0] CSR_LEFT_FWD_IN1   = 3'd3;
   localparam logic [2:0] CSR_RIGHT_FWD_IN1  = 3'd4;

   // Register reset values.
   localparam logic [15:0] TIMEOUT_RESET    = 16'd300;
   localparam logic [7:0]  PERIOD_RESET     = 8'd2;
   localparam logic [7:0]  ON_COUNT_RESET   = 8'd1;
   localparam logic [16:0] TICKS_RESET      = 17'd301;

   // Completed command from the matcher.
   typedef struct packed {
      logic load;
      logic request;
   } pdc_cmd_type;

   // Status of the phase reduction unit.
   typedef struct packed {
      logic       busy;
      logic       done;
      logic [7:0] rem;
   } pdc_mod_stat_type;

   // Motor pin levels, last field in the lowest bit.
   typedef struct packed {
      logic drive_active;
      logic right_in2;
      logic right_in1;
      logic left_in2;
      logic left_in1;
      logic right_pwm;
      logic left_pwm;
   } pdc_pins_type;

   // Expected character at each prefix position.
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = CHAR_D;
         3'd1:    c = CHAR_R;
         3'd2:    c = CHAR_I;
         3'd3:    c = CHAR_V;
         3'd4:    c = CHAR_E;
         3'd5:    c = CHAR_COMMA;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/pdc_cmd_match.sv =====
// ----------------------------------------------------------------------------
// pdc_cmd_match
// Byte matcher for the "DRIVE,<digit>[CR...]LF" command.
// ----------------------------------------------------------------------------
module pdc_cmd_match (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_fire,
   input  logic [7:0]          rx_byte,
   output pdc_pkg::pdc_cmd_type cmd
);
   import pdc_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic       seen_ff, seen_in;
   logic       digit_ff, digit_in;
   logic [2:0] restart_pos;

   // A mismatching 'D' already counts as the first prefix character.
   assign restart_pos = (rx_byte == CHAR_D) ? 3'd1 : 3'd0;

   // Next matcher state for the byte on the input.
   always_comb begin
      pos_in      = pos_ff;
      seen_in     = seen_ff;
      digit_in    = digit_ff;
      cmd.load    = 1'b0;
      cmd.request = digit_ff;
      if (pos_ff < PREFIX_LEN) begin
         if (rx_byte == prefix_char(pos_ff)) begin
            pos_in  = pos_ff + 3'd1;
            seen_in = 1'b0;
         end else begin
            pos_in  = restart_pos;
            seen_in = 1'b0;
         end
      end else if (!seen_ff) begin
         if (rx_byte == CHAR_ZERO || rx_byte == CHAR_ONE) begin
            digit_in = rx_byte[0];
            seen_in  = 1'b1;
         end else begin
            pos_in  = restart_pos;
            seen_in = 1'b0;
         end
      end else if (rx_byte != CHAR_CR) begin
         // Line feed completes the command; anything else just restarts.
         cmd.load = byte_fire && (rx_byte == CHAR_LF);
         pos_in   = restart_pos;
         seen_in  = 1'b0;
      end
   end

   // Matcher state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 3'd0;
         seen_ff  <= 1'b0;
         digit_ff <= 1'b0;
      end else if (byte_fire) begin
         pos_ff   <= pos_in;
         seen_ff  <= seen_in;
         digit_ff <= digit_in;
      end
   end

endmodule

// ===== rtl/core/pdc_phase_mod.sv =====
// ----------------------------------------------------------------------------
// pdc_phase_mod
// Restoring remainder unit: reduces the PWM phase modulo a new period,
// one dividend bit per cycle, eight bits in all.
// ----------------------------------------------------------------------------
module pdc_phase_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [7:0]                dividend,
   input  logic [7:0]                divisor,
   output pdc_pkg::pdc_mod_stat_type stat
);
   import pdc_pkg::*;

   logic [7:0] dividend_ff;
   logic [7:0] divisor_ff;
   logic [7:0] rem_ff, rem_in;
   logic [2:0] count_ff;
   logic       busy_ff;
   logic       done_ff;
   logic [8:0] rem_shift;
   logic [8:0] rem_sub;

   // One restoring step: shift in the next bit, subtract when it fits.
   always_comb begin
      rem_shift = {rem_ff, dividend_ff[7]};
      rem_sub   = rem_shift - {1'b0, divisor_ff};
      if (rem_shift >= {1'b0, divisor_ff}) begin
         rem_in = rem_sub[7:0];
      end else begin
         rem_in = rem_shift[7:0];
      end
   end

   // Control of the step sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 3'd0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= 3'd0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 3'd1;
         if (count_ff == 3'd7) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start) begin
         dividend_ff <= dividend;
         divisor_ff  <= divisor;
         rem_ff      <= 8'd0;
      end else if (busy_ff) begin
         dividend_ff <= {dividend_ff[6:0], 1'b0};
         rem_ff      <= rem_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.rem  = rem_ff;

endmodule

// ===== rtl/core/pdc_tick_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdc_tick_ctrl
// Watchdog counter, drive request and PWM phase; forms the pin levels
// for every tick.
// ----------------------------------------------------------------------------
module pdc_tick_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tick_fire,
   input  pdc_pkg::pdc_cmd_type      cmd,
   input  pdc_pkg::pdc_mod_stat_type mod_stat,
   input  logic [15:0]               timeout_ticks,
   input  logic [7:0]                pwm_period,
   input  logic [7:0]                pwm_on_count,
   input  logic                      left_fwd_in1,
   input  logic                      right_fwd_in1,
   output logic [7:0]                phase,
   output pdc_pkg::pdc_pins_type     pins
);
   import pdc_pkg::*;

   logic [16:0] ticks_ff, ticks_in;
   logic        request_ff;
   logic [7:0]  phase_ff, phase_in;
   logic [8:0]  phase_inc;
   logic        active;
   logic        pwm;

   // Counter stops one past the timeout; phase wraps at the period.
   always_comb begin
      if (ticks_ff <= {1'b0, timeout_ticks}) begin
         ticks_in = ticks_ff + 17'd1;
      end else begin
         ticks_in = ticks_ff;
      end
      phase_inc = {1'b0, phase_ff} + 9'd1;
      if (pwm_period == 8'd0 || phase_inc == {1'b0, pwm_period}) begin
         phase_in = 8'd0;
      end else begin
         phase_in = phase_inc[7:0];
      end
   end

   // Pin levels after this tick's update.
   always_comb begin
      active = request_ff && (ticks_in <= {1'b0, timeout_ticks});
      pwm    = phase_in < pwm_on_count;
      pins.left_pwm     = active & pwm;
      pins.right_pwm    = active & pwm;
      pins.left_in1     = active & left_fwd_in1;
      pins.left_in2     = active & ~left_fwd_in1;
      pins.right_in1    = active & right_fwd_in1;
      pins.right_in2    = active & ~right_fwd_in1;
      pins.drive_active = active;
   end

   // Watchdog, request and phase registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff   <= TICKS_RESET;
         request_ff <= 1'b0;
         phase_ff   <= 8'd0;
      end else begin
         if (cmd.load) begin
            request_ff <= cmd.request;
            ticks_ff   <= 17'd0;
         end else if (tick_fire) begin
            ticks_ff <= ticks_in;
         end
         if (mod_stat.done) begin
            phase_ff <= mod_stat.rem;
         end else if (tick_fire) begin
            phase_ff <= phase_in;
         end
      end
   end

   assign phase = phase_ff;

endmodule

// ===== rtl/core/pdc_rsp_skid.sv =====
// ----------------------------------------------------------------------------
// pdc_rsp_skid
// Result register with a skid stage, so an item is taken while a result
// still waits downstream.
// ----------------------------------------------------------------------------
module pdc_rsp_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  pdc_pkg::pdc_pins_type in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output pdc_pkg::pdc_pins_type out_data,
   input  logic                  out_ready
);
   import pdc_pkg::*;

   logic         out_valid_ff;
   logic         skid_valid_ff;
   pdc_pins_type out_data_ff;
   pdc_pins_type skid_data_ff;

   assign in_ready = !skid_valid_ff;

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else begin
            out_data_ff <= in_data;
         end
      end else if (in_valid) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== rtl/core/drive_command_parser_with_watchdog.sv =====
// ----------------------------------------------------------------------------
// drive_command_parser_with_watchdog
// Serial drive command parser with command watchdog and software PWM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  req_      in         req_tvalid/tready     tdata: rx_byte; tuser: mode
//  rsp_      out        rsp_tvalid/tready     tdata: seven pin levels
//  csr_      in         csr_valid/ready       csr_index, csr_data
//
//  An item's state update and its pin levels are formed between the input and
//  the result register. A byte gives no result; a tick gives one result, held
//  in the result register or, while a result waits there, in its skid stage.
//  Writing a nonzero PWM period starts a phase reduction in the remainder
//  unit; req_tready is low while the reduction runs and in the following
//  cycle, in which the reduced phase is stored.
//  The result register and its skid stage keep req_tready high while one
//  result waits; a second waiting result stalls the input.
//  Synchronous reset restores all but the remainder and skid data registers.
// ----------------------------------------------------------------------------
module drive_command_parser_with_watchdog (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] mode (0 byte, 1 tick)
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] left_pwm, [1] right_pwm, [2] left_in1,
                                    // [3] left_in2, [4] right_in1, [5] right_in2,
                                    // [6] drive_active, [7] zero
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import pdc_pkg::*;

   logic [15:0]      timeout_ff;
   logic [7:0]       period_ff;
   logic [7:0]       on_count_ff;
   logic             left_fwd_ff;
   logic             right_fwd_ff;
   logic             csr_fire;
   logic             req_fire;
   logic             byte_fire;
   logic             tick_fire;
   logic             skid_ready;
   logic             mod_start;
   logic [7:0]       phase;
   pdc_cmd_type      cmd;
   pdc_mod_stat_type mod_stat;
   pdc_pins_type     pins;
   pdc_pins_type     rsp_pins;

   // Handshakes. The input also waits out the cycle that stores the reduced phase.
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_tready = skid_ready && !mod_stat.busy && !mod_stat.done;
   assign req_fire  = req_tvalid && req_tready;
   assign byte_fire = req_fire && !req_tuser;
   assign tick_fire = req_fire && req_tuser;

   // A new nonzero period reduces the stored phase into range.
   assign mod_start = csr_fire && (csr_index == CSR_PWM_PERIOD) && (csr_data[7:0] != 8'd0);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         period_ff    <= PERIOD_RESET;
         on_count_ff  <= ON_COUNT_RESET;
         left_fwd_ff  <= 1'b1;
         right_fwd_ff <= 1'b1;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS: timeout_ff   <= csr_data;
            CSR_PWM_PERIOD:    period_ff    <= csr_data[7:0];
            CSR_PWM_ON_COUNT:  on_count_ff  <= csr_data[7:0];
            CSR_LEFT_FWD_IN1:  left_fwd_ff  <= csr_data[0];
            CSR_RIGHT_FWD_IN1: right_fwd_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   pdc_cmd_match u_match (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .rx_byte   (req_tdata),
      .cmd       (cmd)
   );

   pdc_phase_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (phase),
      .divisor  (csr_data[7:0]),
      .stat     (mod_stat)
   );

   pdc_tick_ctrl u_tick (
      .clock         (clock),
      .reset         (reset),
      .tick_fire     (tick_fire),
      .cmd           (cmd),
      .mod_stat      (mod_stat),
      .timeout_ticks (timeout_ff),
      .pwm_period    (period_ff),
      .pwm_on_count  (on_count_ff),
      .left_fwd_in1  (left_fwd_ff),
      .right_fwd_in1 (right_fwd_ff),
      .phase         (phase),
      .pins          (pins)
   );

   pdc_rsp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tick_fire),
      .in_data   (pins),
      .in_ready  (skid_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_pins),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0, rsp_pins};

   // While the phase is being reduced no item may enter.
   a_busy_stalls : assert property (@(posedge clock) disable iff (reset)
      mod_stat.busy |-> !req_tready)
      else $error("item accepted during phase reduction");

   // A nonzero period write holds off the input in the next cycle.
   a_period_write_stalls : assert property (@(posedge clock) disable iff (reset)
      mod_start |=> !req_tready)
      else $error("input not stalled after period write");

   // A stopped result drives every pin low.
   a_stopped_pins_low : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[6]) |-> (rsp_tdata[5:0] == 6'd0))
      else $error("pins driven while drive is inactive");

endmodule
